// ===== rtl/scar_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scar_pkg
// shared types and defaults of the cache tag and replacement unit
// ----------------------------------------------------------------------------
package scar_pkg;

  // default geometry
  localparam int DEF_ADDR_BITS   = 20;
  localparam int DEF_SET_BITS    = 8;
  localparam int DEF_WAYS        = 4;
  localparam int DEF_OFFSET_BITS = 4;
  localparam int DEF_AGE_BITS    = 16;

  // result port widths
  localparam int OUT_SET_W  = 8;
  localparam int OUT_WAY_W  = 2;
  localparam int OUT_TAG_W  = 8;
  localparam int OUT_FILL_W = 3;

  typedef enum logic [0:0] {
    POLICY_LRU  = 1'b0,
    POLICY_FIFO = 1'b1
  } policy_t;

  typedef struct packed {
    logic                  hit;
    logic [OUT_SET_W-1:0]  set_sel;
    logic [OUT_WAY_W-1:0]  way;
    logic                  evicted;
    logic [OUT_TAG_W-1:0]  evicted_tag;
    logic [OUT_FILL_W-1:0] set_fill;
  } res_t;

endpackage

// ===== rtl/scar_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scar_ram
// simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module scar_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/scar_way_logic.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scar_way_logic
// per-set lookup: aging, tag compare, fill or victim choice, new set row
// ----------------------------------------------------------------------------
module scar_way_logic
  import scar_pkg::*;
#(
  parameter int WAYS   = DEF_WAYS,
  parameter int TAG_W  = 8,
  parameter int AGE_W  = DEF_AGE_BITS,
  parameter int FILL_W = 3,
  parameter int WAY_W  = 2
) (
  input  policy_t                 policy,
  input  logic [OUT_SET_W-1:0]    set_in,
  input  logic [TAG_W-1:0]        tag,
  input  logic [WAYS*TAG_W-1:0]   tags_in,
  input  logic [WAYS*AGE_W-1:0]   ages_in,
  input  logic [FILL_W-1:0]       fill_in,
  output logic [WAYS*TAG_W-1:0]   tags_out,
  output logic [WAYS*AGE_W-1:0]   ages_out,
  output logic [FILL_W-1:0]       fill_out,
  output res_t                    res
);

  localparam int LVL = (WAYS > 1) ? $clog2(WAYS) : 0;
  localparam int P   = 1 << LVL;

  logic [FILL_W-1:0] fill;
  logic [WAYS-1:0]   line_vld;
  logic [WAYS-1:0]   match;
  logic [AGE_W-1:0]  age_inc [WAYS];
  logic [AGE_W-1:0]  tr_age  [P];
  logic [WAY_W-1:0]  tr_idx  [P];
  logic              hit;
  logic              full;
  logic [WAY_W-1:0]  hit_way;
  logic [WAY_W-1:0]  victim;
  logic [WAY_W-1:0]  way;

  always_comb begin
    fill = (fill_in > FILL_W'(WAYS)) ? FILL_W'(WAYS) : fill_in;
    full = (fill == FILL_W'(WAYS));

    // age every valid line, saturating
    for (int j = 0; j < WAYS; j++) begin
      line_vld[j] = (FILL_W'(j) < fill);
      age_inc[j]  = ages_in[j*AGE_W +: AGE_W];
      if (line_vld[j] && (age_inc[j] != '1)) begin
        age_inc[j] = age_inc[j] + AGE_W'(1);
      end
      match[j] = line_vld[j] && (tags_in[j*TAG_W +: TAG_W] == tag);
    end
    hit = |match;

    // lowest matching way
    hit_way = '0;
    for (int j = WAYS - 1; j >= 0; j--) begin
      if (match[j]) begin
        hit_way = WAY_W'(j);
      end
    end

    // oldest line, lower way wins a tie; padding never wins
    for (int i = 0; i < P; i++) begin
      tr_age[i] = (i < WAYS) ? age_inc[i] : '0;
      tr_idx[i] = WAY_W'(i);
    end
    for (int l = 0; l < LVL; l++) begin
      for (int i = 0; i < P; i += (2 << l)) begin
        if (tr_age[i + (1 << l)] > tr_age[i]) begin
          tr_age[i] = tr_age[i + (1 << l)];
          tr_idx[i] = tr_idx[i + (1 << l)];
        end
      end
    end
    victim = tr_idx[0];

    priority if (hit) begin
      way = hit_way;
    end else if (full) begin
      way = victim;
    end else begin
      way = WAY_W'(fill);
    end

    // new set row
    tags_out = tags_in;
    for (int j = 0; j < WAYS; j++) begin
      ages_out[j*AGE_W +: AGE_W] = age_inc[j];
      if (match[j] && (policy == POLICY_LRU)) begin
        ages_out[j*AGE_W +: AGE_W] = '0;
      end
      if (!hit && (WAY_W'(j) == way)) begin
        ages_out[j*AGE_W +: AGE_W] = '0;
        tags_out[j*TAG_W +: TAG_W] = tag;
      end
    end
    fill_out = (!hit && !full) ? fill + FILL_W'(1) : fill;

    res.hit         = hit;
    res.set_sel     = set_in;
    res.way         = OUT_WAY_W'(way);
    res.evicted     = !hit && full;
    res.evicted_tag = (!hit && full) ? OUT_TAG_W'(tags_in[way*TAG_W +: TAG_W])
                                     : '0;
    res.set_fill    = OUT_FILL_W'(fill_out);
  end

endmodule

// ===== rtl/set_assoc_cache_tag_replacement_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// set_assoc_cache_tag_replacement_unit
// set-associative tag lookup with lru or fifo replacement
// ----------------------------------------------------------------------------
//
//  channel  ports                              handshake
//  -------  ---------------------------------  ---------------------------
//  in       in_address                         start & !busy
//  out      out_hit .. out_set_fill            out_valid, one-cycle strobe
//  cfg      cfg_policy                         cfg_valid & cfg_ready
//
//  one access per cycle while busy is low; each accept strobes one result
//  (set rows are read from ram at the accept edge, the set logic runs in
//  the next cycle, the result register follows)
//  an access to the set that the previous access is updating takes the
//  row forwarded from that access, since the ram write lands at the same edge
//  reset clears the per-set fill valid bits at once, there is no clearing
//  pass; busy is high during reset and the cycle after it
//  the receiver cannot stall, so busy never holds off accesses otherwise
//
module set_assoc_cache_tag_replacement_unit
  import scar_pkg::*;
#(
  parameter int ADDR_BITS   = DEF_ADDR_BITS,
  parameter int SET_BITS    = DEF_SET_BITS,
  parameter int WAYS        = DEF_WAYS,
  parameter int OFFSET_BITS = DEF_OFFSET_BITS,
  parameter int AGE_BITS    = DEF_AGE_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // access words
  input  logic                  start,
  output logic                  busy,
  input  logic [ADDR_BITS-1:0]  in_address,
  // result words
  output logic                  out_valid,
  output logic                  out_hit,
  output logic [OUT_SET_W-1:0]  out_set_index,
  output logic [OUT_WAY_W-1:0]  out_way,
  output logic                  out_evicted,
  output logic [OUT_TAG_W-1:0]  out_evicted_tag,
  output logic [OUT_FILL_W-1:0] out_set_fill,
  // policy register
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic                  cfg_policy
);

  // tag field may be empty when offset and set cover the address
  localparam int TAG_RAW  = ADDR_BITS - OFFSET_BITS - SET_BITS;
  localparam int TAG_W    = (TAG_RAW > 0) ? TAG_RAW : 1;
  localparam int NUM_SETS = 1 << SET_BITS;
  localparam int FILL_W   = $clog2(WAYS + 1);
  localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int TROW_W   = WAYS * TAG_W;
  localparam int AROW_W   = WAYS * AGE_BITS;

  logic                busy_r;
  policy_t             policy_r;
  logic                s1_valid_r;
  logic [SET_BITS-1:0] s1_set_r;
  logic [TAG_W-1:0]    s1_tag_r;
  logic                fwd_r;
  logic                fwd_nxt;
  logic [TROW_W-1:0]   fwd_tags_r;
  logic [AROW_W-1:0]   fwd_ages_r;
  logic [FILL_W-1:0]   fwd_fill_r;
  logic [NUM_SETS-1:0] set_vld_r;
  logic                out_valid_r;
  res_t                out_res_r;

  logic                accept;
  logic [SET_BITS-1:0] in_set;
  logic [TAG_W-1:0]    in_tag;
  logic [TROW_W-1:0]   tag_rdata;
  logic [AROW_W-1:0]   age_rdata;
  logic [FILL_W-1:0]   fill_rdata;
  logic [TROW_W-1:0]   cur_tags;
  logic [AROW_W-1:0]   cur_ages;
  logic [FILL_W-1:0]   cur_fill;
  logic [TROW_W-1:0]   new_tags;
  logic [AROW_W-1:0]   new_ages;
  logic [FILL_W-1:0]   new_fill;
  res_t                res;

  assign busy      = busy_r || !rst_n;
  assign cfg_ready = rst_n && !busy_r;
  assign accept    = start && !busy;

  // address split; shifts leave zero for an empty tag field
  assign in_set = SET_BITS'(in_address >> OFFSET_BITS);
  assign in_tag = TAG_W'(in_address >> (OFFSET_BITS + SET_BITS));

  // set rows: tags, ages and fill count, one row per set
  scar_ram #(.WIDTH(TROW_W), .DEPTH(NUM_SETS)) u_tag_ram (
    .clk   (clk),
    .we    (s1_valid_r),
    .waddr (s1_set_r),
    .wdata (new_tags),
    .raddr (in_set),
    .rdata (tag_rdata)
  );

  scar_ram #(.WIDTH(AROW_W), .DEPTH(NUM_SETS)) u_age_ram (
    .clk   (clk),
    .we    (s1_valid_r),
    .waddr (s1_set_r),
    .wdata (new_ages),
    .raddr (in_set),
    .rdata (age_rdata)
  );

  scar_ram #(.WIDTH(FILL_W), .DEPTH(NUM_SETS)) u_fill_ram (
    .clk   (clk),
    .we    (s1_valid_r),
    .waddr (s1_set_r),
    .wdata (new_fill),
    .raddr (in_set),
    .rdata (fill_rdata)
  );

  // forwarded row wins; a set never written has no lines
  always_comb begin
    cur_tags = fwd_r ? fwd_tags_r : tag_rdata;
    cur_ages = fwd_r ? fwd_ages_r : age_rdata;
    priority if (fwd_r) begin
      cur_fill = fwd_fill_r;
    end else if (set_vld_r[s1_set_r]) begin
      cur_fill = fill_rdata;
    end else begin
      cur_fill = '0;
    end
  end

  scar_way_logic #(
    .WAYS   (WAYS),
    .TAG_W  (TAG_W),
    .AGE_W  (AGE_BITS),
    .FILL_W (FILL_W),
    .WAY_W  (WAY_W)
  ) u_way_logic (
    .policy   (policy_r),
    .set_in   (OUT_SET_W'(s1_set_r)),
    .tag      (s1_tag_r),
    .tags_in  (cur_tags),
    .ages_in  (cur_ages),
    .fill_in  (cur_fill),
    .tags_out (new_tags),
    .ages_out (new_ages),
    .fill_out (new_fill),
    .res      (res)
  );

  // back-to-back access to the set being written
  assign fwd_nxt = s1_valid_r && accept && (in_set == s1_set_r);

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b1;
      policy_r    <= POLICY_LRU;
      s1_valid_r  <= 1'b0;
      fwd_r       <= 1'b0;
      set_vld_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= 1'b0;
      s1_valid_r  <= accept;
      fwd_r       <= fwd_nxt;
      out_valid_r <= s1_valid_r;
      if (cfg_valid && cfg_ready) begin
        policy_r <= policy_t'(cfg_policy);
      end
      if (s1_valid_r) begin
        set_vld_r[s1_set_r] <= 1'b1;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_set_r <= in_set;
      s1_tag_r <= in_tag;
    end
    if (s1_valid_r) begin
      fwd_tags_r <= new_tags;
      fwd_ages_r <= new_ages;
      fwd_fill_r <= new_fill;
      out_res_r  <= res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_hit         = out_res_r.hit;
  assign out_set_index   = out_res_r.set_sel;
  assign out_way         = out_res_r.way;
  assign out_evicted     = out_res_r.evicted;
  assign out_evicted_tag = out_res_r.evicted_tag;
  assign out_set_fill    = out_res_r.set_fill;

`ifndef NO_ASSERTIONS
  // every accepted access strobes a result through the set stage and the result register
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> ##1 out_valid_r)
    else $error("accepted access produced no result");

  // forwarding only ever feeds an access that is in the set stage
  a_fwd_in_stage: assert property (@(posedge clk) disable iff (!rst_n)
    fwd_r |-> s1_valid_r)
    else $error("forwarded row without an access in the set stage");

  // a hit never evicts
  a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_res_r.hit && out_res_r.evicted))
    else $error("hit reported with an eviction");

  // eviction only out of a full set
  a_evict_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.evicted) |-> (out_res_r.set_fill == OUT_FILL_W'(WAYS)))
    else $error("eviction from a set that was not full");
`endif

endmodule

// ===== verif/cache_tag_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cache_tag_checker
// watches the access, result and policy channels of the tag unit, keeps its
// own copy of tags, ages and fill counts, and compares every result word
// ----------------------------------------------------------------------------
module cache_tag_checker
  import scar_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic                   busy,
  input  logic [DEF_ADDR_BITS-1:0] in_address,
  input  logic                   out_valid,
  input  logic                   out_hit,
  input  logic [OUT_SET_W-1:0]   out_set_index,
  input  logic [OUT_WAY_W-1:0]   out_way,
  input  logic                   out_evicted,
  input  logic [OUT_TAG_W-1:0]   out_evicted_tag,
  input  logic [OUT_FILL_W-1:0]  out_set_fill,
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  logic                   cfg_policy,
  output int                     fail_count,
  output int                     pending,
  output int                     hit_total,
  output int                     evict_total
);

  localparam int NSETS   = 1 << DEF_SET_BITS;
  localparam int TAG_LSB = DEF_OFFSET_BITS + DEF_SET_BITS;
  localparam logic [DEF_AGE_BITS-1:0] AGE_SAT = '1;

  logic [OUT_TAG_W-1:0]    tag_mem [NSETS][DEF_WAYS];
  logic [DEF_AGE_BITS-1:0] line_age [NSETS][DEF_WAYS];
  int                      lines_valid [NSETS];
  policy_t                 cur_policy;
  res_t                    expected_lookups [$];

  initial begin
    fail_count  = 0;
    pending     = 0;
    hit_total   = 0;
    evict_total = 0;
    cur_policy  = POLICY_LRU;
    for (int s = 0; s < NSETS; s++) lines_valid[s] = 0;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    fail_count++;
    if (fail_count <= 30)
      $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
  endtask

  // lookup, aging and replacement of one access
  task automatic lookup_and_replace(input logic [DEF_ADDR_BITS-1:0] a, output res_t r);
    logic [OUT_SET_W-1:0]    s;
    logic [OUT_TAG_W-1:0]    t;
    logic [DEF_AGE_BITS-1:0] oldest;
    int                      n;
    int                      w;
    bit                      found;
    s = a[TAG_LSB-1:DEF_OFFSET_BITS];
    t = a[DEF_ADDR_BITS-1:TAG_LSB];
    n = lines_valid[s];
    w = 0;
    found = 1'b0;
    r = '0;
    for (int j = 0; j < n; j++) begin
      if (line_age[s][j] != AGE_SAT) line_age[s][j]++;
      if (tag_mem[s][j] == t) begin
        if (cur_policy == POLICY_LRU) line_age[s][j] = '0;
        if (!found) w = j;
        found = 1'b1;
      end
    end
    if (!found) begin
      if (n < DEF_WAYS) begin
        w = n;
        n++;
        lines_valid[s] = n;
      end else begin
        // lowest way wins a tie
        oldest = '0;
        for (int j = 0; j < DEF_WAYS; j++) begin
          if (line_age[s][j] > oldest) begin
            oldest = line_age[s][j];
            w = j;
          end
        end
        r.evicted     = 1'b1;
        r.evicted_tag = tag_mem[s][w];
      end
      tag_mem[s][w]  = t;
      line_age[s][w] = '0;
    end
    r.hit      = found;
    r.set_sel  = s;
    r.way      = OUT_WAY_W'(w);
    r.set_fill = OUT_FILL_W'(n);
  endtask

  always @(posedge clk) begin
    res_t got;
    res_t want;
    res_t predicted;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) cur_policy = policy_t'(cfg_policy);
      if (out_valid) begin
        got = '{out_hit, out_set_index, out_way, out_evicted, out_evicted_tag, out_set_fill};
        if (expected_lookups.size() == 0) begin
          report_mismatch("unexpected result word, set", got.set_sel, -1);
        end else begin
          want = expected_lookups.pop_front();
          if (got.hit !== want.hit) report_mismatch("hit", got.hit, want.hit);
          if (got.set_sel !== want.set_sel)
            report_mismatch("set", got.set_sel, want.set_sel);
          if (got.way !== want.way) report_mismatch("way", got.way, want.way);
          if (got.evicted !== want.evicted)
            report_mismatch("evicted", got.evicted, want.evicted);
          if (got.evicted_tag !== want.evicted_tag)
            report_mismatch("evicted_tag", got.evicted_tag, want.evicted_tag);
          if (got.set_fill !== want.set_fill)
            report_mismatch("set_fill", got.set_fill, want.set_fill);
          if (want.hit) hit_total++;
          if (want.evicted) evict_total++;
        end
      end
      if (start && !busy) begin
        lookup_and_replace(in_address, predicted);
        expected_lookups.insert(expected_lookups.size(), predicted);
      end
    end
    pending = expected_lookups.size();
  end

endmodule

// ===== verif/set_assoc_cache_tag_replacement_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// set_assoc_cache_tag_replacement_unit_tb
// drives address words into the tag unit under both replacement policies,
// with directed corner accesses, hot-set random traffic and a fifo
// eviction order run; the checker beside the block predicts and compares
// ----------------------------------------------------------------------------
module set_assoc_cache_tag_replacement_unit_tb;
  import scar_pkg::*;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int FIFO_HITS      = 20;      // hits that keep the fifo lines aging

  logic                     clk;
  logic                     rst_n;
  logic                     start;
  logic                     busy;
  logic [DEF_ADDR_BITS-1:0] in_address;
  logic                     out_valid;
  logic                     out_hit;
  logic [OUT_SET_W-1:0]     out_set_index;
  logic [OUT_WAY_W-1:0]     out_way;
  logic                     out_evicted;
  logic [OUT_TAG_W-1:0]     out_evicted_tag;
  logic [OUT_FILL_W-1:0]    out_set_fill;
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic                     cfg_policy;

  int fail_count;
  int pending;
  int hit_total;
  int evict_total;
  int words_sent;
  bit gaps_on;

  set_assoc_cache_tag_replacement_unit dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_address      (in_address),
    .out_valid       (out_valid),
    .out_hit         (out_hit),
    .out_set_index   (out_set_index),
    .out_way         (out_way),
    .out_evicted     (out_evicted),
    .out_evicted_tag (out_evicted_tag),
    .out_set_fill    (out_set_fill),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_policy      (cfg_policy)
  );

  cache_tag_checker checker_i (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_address      (in_address),
    .out_valid       (out_valid),
    .out_hit         (out_hit),
    .out_set_index   (out_set_index),
    .out_way         (out_way),
    .out_evicted     (out_evicted),
    .out_evicted_tag (out_evicted_tag),
    .out_set_fill    (out_set_fill),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_policy      (cfg_policy),
    .fail_count      (fail_count),
    .pending         (pending),
    .hit_total       (hit_total),
    .evict_total     (evict_total)
  );

  // 8 ns clock
  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // tag above set above offset
  function automatic logic [DEF_ADDR_BITS-1:0] line_addr(input logic [7:0] tag,
                                                         input logic [7:0] set,
                                                         input logic [3:0] off);
    return {tag, set, off};
  endfunction

  // mostly a few hot sets and tags so sets fill, hit and evict;
  // the rest spreads over the whole address space
  function automatic logic [DEF_ADDR_BITS-1:0] pick_address();
    logic [7:0] s;
    logic [7:0] t;
    if ($urandom_range(99) >= 75) return DEF_ADDR_BITS'($urandom);
    case ($urandom_range(5))
      0: s = 8'h00;
      1: s = 8'h01;
      2: s = 8'h55;
      3: s = 8'hAA;
      4: s = 8'hFE;
      default: s = 8'hFF;
    endcase
    case ($urandom_range(5))
      0: t = 8'h00;
      1: t = 8'h01;
      2: t = 8'h02;
      3: t = 8'h80;
      4: t = 8'h7E;
      default: t = 8'hFF;
    endcase
    return line_addr(t, s, 4'($urandom));
  endfunction

  // called at a falling edge; returns at the falling edge after the accept,
  // where the caller must drive start again
  task automatic push_access(input logic [DEF_ADDR_BITS-1:0] a);
    while (gaps_on && $urandom_range(99) < 16) begin
      start      <= 1'b0;
      in_address <= DEF_ADDR_BITS'($urandom);
      @(negedge clk);
    end
    start      <= 1'b1;
    in_address <= a;
    do @(posedge clk); while (busy);
    words_sent++;
    @(negedge clk);
  endtask

  // stop sending and wait until every result word has come back
  task automatic drain();
    start <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  // policy writes happen only with the unit drained
  task automatic write_policy(input policy_t p);
    cfg_valid  <= 1'b1;
    cfg_policy <= p;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_traffic(input int n, input int calm_from, input int calm_to);
    for (int i = 0; i < n; i++) begin
      gaps_on = !(i >= calm_from && i < calm_to);
      // now and then let the pipe empty completely
      if ($urandom_range(199) == 0) drain();
      push_access(pick_address());
    end
    gaps_on = 1'b1;
  endtask

  // watchdog: any accept, result or policy write resets the count
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((start && !busy) || out_valid || (cfg_valid && cfg_ready)) quiet = 0;
      else quiet++;
    end
    $display("watchdog: no traffic for %0d cycles, %0d results outstanding",
             WATCHDOG_LIMIT, pending);
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    logic [7:0] sat_tags [4];
    rst_n      = 1'b0;
    start      = 1'b0;
    in_address = '0;
    cfg_valid  = 1'b0;
    cfg_policy = 1'b0;
    words_sent = 0;
    gaps_on    = 1'b1;
    sat_tags   = '{8'h11, 8'h22, 8'h33, 8'h44};

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    write_policy(POLICY_LRU);

    // directed: address extremes, fill, hit, lru refresh and eviction
    push_access(line_addr(8'h00, 8'h00, 4'h0));
    push_access(line_addr(8'hFF, 8'hFF, 4'hF));
    push_access(line_addr(8'h00, 8'h00, 4'hF));   // hit, offset ignored
    push_access(line_addr(8'h01, 8'h10, 4'h0));
    push_access(line_addr(8'h02, 8'h10, 4'h5));
    push_access(line_addr(8'h03, 8'h10, 4'hA));
    push_access(line_addr(8'h04, 8'h10, 4'hF));   // set now full
    push_access(line_addr(8'h01, 8'h10, 4'h0));   // refresh way 0
    push_access(line_addr(8'h05, 8'h10, 4'h0));   // evicts the stalest
    push_access(line_addr(8'h02, 8'h10, 4'h0));
    push_access(line_addr(8'h03, 8'h10, 4'h0));
    push_access(line_addr(8'h05, 8'h10, 4'h3));
    push_access(line_addr(8'h80, 8'h01, 4'h0));   // same tag, other sets
    push_access(line_addr(8'h80, 8'h02, 4'h0));
    push_access(line_addr(8'h80, 8'h01, 4'h0));
    push_access(line_addr(8'h7F, 8'h80, 4'h8));
    push_access(line_addr(8'h7F, 8'h80, 4'h8));
    push_access(line_addr(8'h00, 8'hFF, 4'h0));
    push_access(line_addr(8'hFF, 8'h00, 4'h0));
    drain();

    random_traffic(450, 150, 300);
    drain();

    write_policy(POLICY_FIFO);
    random_traffic(400, 0, 0);

    // fifo order: four fresh lines in one set, hits keep them aging in
    // fill order, then misses must take the oldest fills first
    for (int i = 0; i < 4; i++) push_access(line_addr(sat_tags[i], 8'h33, 4'h0));
    for (int i = 0; i < FIFO_HITS; i++)
      push_access(line_addr(sat_tags[i % 4], 8'h33, 4'($urandom)));
    push_access(line_addr(8'h55, 8'h33, 4'h0));
    push_access(line_addr(8'h66, 8'h33, 4'h0));
    push_access(line_addr(8'h11, 8'h33, 4'h0));
    drain();

    write_policy(POLICY_LRU);
    random_traffic(400, 100, 250);
    drain();
    repeat (4) @(negedge clk);

    $display("covered %0d access words: %0d hits, %0d evictions", words_sent,
             hit_total, evict_total);
    $display("policies lru and fifo, hot-set traffic, fifo eviction order");
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/scar_pkg.sv
rtl/scar_ram.sv
rtl/scar_way_logic.sv
rtl/set_assoc_cache_tag_replacement_unit.sv
verif/cache_tag_checker.sv
verif/set_assoc_cache_tag_replacement_unit_tb.sv
